FILE: rtl/core/ray_disk_intersection_core_defines.svh
// ----------------------------------------------------------------------------
// Ray/disk intersection core: assertion macros
// Shared concurrent assertion forms for the core's checker.
// ----------------------------------------------------------------------------
`ifndef RAY_DISK_INTERSECTION_CORE_DEFINES_SVH
`define RAY_DISK_INTERSECTION_CORE_DEFINES_SVH

// assertion sampled on the clock, switched off while reset is high
`define RDI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion sampled on the clock, active during reset too
`define RDI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/rdi_pkg.sv
// ----------------------------------------------------------------------------
// rdi_pkg
// Types and constants shared by the ray/disk intersection core.
// ----------------------------------------------------------------------------
package rdi_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT   = 16;

   localparam int NORM_WIDTH   = 16;
   localparam int NORM_FRAC    = 14;
   localparam int RADIUS_WIDTH = 31;
   localparam int EPS_WIDTH    = 16;

   localparam logic signed [NORM_WIDTH-1:0] NORMAL_X_RESET = 16'sd0;
   localparam logic signed [NORM_WIDTH-1:0] NORMAL_Y_RESET = 16'sd16384;
   localparam logic signed [NORM_WIDTH-1:0] NORMAL_Z_RESET = 16'sd0;
   localparam logic [RADIUS_WIDTH-1:0]      RADIUS_RESET   = 31'd65536;
   localparam logic [EPS_WIDTH-1:0]         EPS_RESET      = 16'd16;

   typedef enum logic [1:0] {
      STATUS_HIT      = 2'd0,
      STATUS_PARALLEL = 2'd1,
      STATUS_OUTSIDE  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CSR_CENTRE_X = 3'd0,
      CSR_CENTRE_Y = 3'd1,
      CSR_CENTRE_Z = 3'd2,
      CSR_NORMAL_X = 3'd3,
      CSR_NORMAL_Y = 3'd4,
      CSR_NORMAL_Z = 3'd5,
      CSR_RADIUS   = 3'd6,
      CSR_EPSILON  = 3'd7
   } csr_index_type;

   // control travelling alongside the divider pipeline
   typedef struct packed {
      logic valid;
      logic neg;
      logic parallel;
   } div_ctrl_type;

endpackage

FILE: rtl/core/rdi_divider.sv
// ----------------------------------------------------------------------------
// rdi_divider
// Pipelined restoring divider: one quotient bit per stage, saturation flag.
// ----------------------------------------------------------------------------
module rdi_divider #(
   parameter int NUM_W     = 51,
   parameter int DEN_W     = 50,
   parameter int QUOT_W    = 31,
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W    = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rdi_pkg::div_ctrl_type in_ctrl,
   input  logic [NUM_W-1:0]     in_num,
   input  logic [DEN_W-1:0]     in_den,
   input  logic [SIDE_W-1:0]    in_side,
   output rdi_pkg::div_ctrl_type out_ctrl,
   output logic [QUOT_W-1:0]    out_quot,
   output logic                 out_sat,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int AW = NUM_W + FRAC_BITS;
   localparam int RW = DEN_W + 1;

   logic [AW-1:0] dividend;
   logic [AW-1:0] dividend_hi;

   rdi_pkg::div_ctrl_type ctrl_ff [0:QUOT_W];
   logic [QUOT_W-1:0]     quot_ff [0:QUOT_W];
   logic                  sat_ff  [0:QUOT_W];
   logic [SIDE_W-1:0]     side_ff [0:QUOT_W];
   logic [RW-1:0]         rem_ff  [0:QUOT_W-1];
   logic [QUOT_W-1:0]     low_ff  [0:QUOT_W-1];
   logic [DEN_W-1:0]      den_ff  [0:QUOT_W-1];

   assign dividend    = {in_num, {FRAC_BITS{1'b0}}};
   assign dividend_hi = dividend >> QUOT_W;

   // entry: quotient too big for the result range -> saturate
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff[0] <= '0;
      end else begin
         ctrl_ff[0] <= in_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff[0]  <= dividend_hi >= AW'(in_den);
      rem_ff[0]  <= dividend_hi[RW-1:0];
      quot_ff[0] <= '0;
      low_ff[0]  <= dividend[QUOT_W-1:0];
      den_ff[0]  <= in_den;
      side_ff[0] <= in_side;
   end

   for (genvar s = 1; s <= QUOT_W; s++) begin : g_step
      logic [RW-1:0] trial;
      logic [RW-1:0] diff;
      logic          take;

      assign trial = {rem_ff[s-1][RW-2:0], low_ff[s-1][QUOT_W-s]};
      assign diff  = trial - RW'(den_ff[s-1]);
      assign take  = trial >= RW'(den_ff[s-1]);

      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_ff[s] <= '0;
         end else begin
            ctrl_ff[s] <= ctrl_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         quot_ff[s] <= {quot_ff[s-1][QUOT_W-2:0], take};
         sat_ff[s]  <= sat_ff[s-1];
         side_ff[s] <= side_ff[s-1];
      end

      if (s < QUOT_W) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[s] <= take ? diff : trial;
            low_ff[s] <= low_ff[s-1];
            den_ff[s] <= den_ff[s-1];
         end
      end
   end

   assign out_ctrl = ctrl_ff[QUOT_W];
   assign out_quot = quot_ff[QUOT_W];
   assign out_sat  = sat_ff[QUOT_W];
   assign out_side = side_ff[QUOT_W];

endmodule

FILE: rtl/core/ray_disk_intersection_core.sv
// ----------------------------------------------------------------------------
// ray_disk_intersection_core
// Fixed-point ray against flat disk test, fully pipelined, one ray per cycle.
// ----------------------------------------------------------------------------
//  channel  ports                         handshake
//  ray in   start, busy, req_ray_*        item taken when start && !busy
//  result   rsp_valid, rsp_hit_*          one-cycle strobe, no back-pressure
//  csr      csr_we, csr_index, csr_wdata  write when csr_we, no read-back
//
// One item per cycle sustained; each result passes the entry stages, the divider,
// the hit-test stages and the result register. The divider sets the depth: one quotient bit per stage.
// busy is high only while reset is high; synchronous reset empties the pipe.
// Results cannot be held off, so nothing in the pipe ever waits.
// ----------------------------------------------------------------------------
module ray_disk_intersection_core #(
   parameter int COORD_WIDTH = rdi_pkg::COORD_WIDTH_DEFAULT,
   parameter int FRAC_BITS   = rdi_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // ray items
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_ray_origin_x,
   input  logic signed [COORD_WIDTH-1:0] req_ray_origin_y,
   input  logic signed [COORD_WIDTH-1:0] req_ray_origin_z,
   input  logic signed [COORD_WIDTH-1:0] req_ray_dir_x,
   input  logic signed [COORD_WIDTH-1:0] req_ray_dir_y,
   input  logic signed [COORD_WIDTH-1:0] req_ray_dir_z,
   // results
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_hit_status,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_distance,
   // registers
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [((COORD_WIDTH > rdi_pkg::RADIUS_WIDTH) ? COORD_WIDTH
                  : rdi_pkg::RADIUS_WIDTH)-1:0] csr_wdata
);

   localparam int CW     = COORD_WIDTH;
   localparam int NW     = rdi_pkg::NORM_WIDTH;
   localparam int RW     = rdi_pkg::RADIUS_WIDTH;
   localparam int NDW    = NW + CW;          // n * d
   localparam int NCW    = NW + CW + 1;      // n * (c - o)
   localparam int DEN_W  = NW + CW + 2;      // n.d
   localparam int NUM_W  = NW + CW + 3;      // n.(c - o)
   localparam int QUOT_W = CW - 1;
   localparam int SIDE_W = 3 * (CW + 1) + 3 * CW;
   localparam int PW     = 2 * CW;           // t * d
   localparam int EW     = 2 * CW + 1;       // hit offset from centre
   localparam int SW     = 2 * RW + 2;       // sum of squares
   localparam int LATENCY = CW + 13;

   // ---- configuration registers ----
   logic signed [CW-1:0]     centre_ff [3];
   logic signed [NW-1:0]     normal_ff [3];
   logic [RW-1:0]            radius_ff;
   logic [rdi_pkg::EPS_WIDTH-1:0] eps_ff;
   logic [2*RW-1:0]          radius_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_ff[0] <= '0;
         centre_ff[1] <= '0;
         centre_ff[2] <= '0;
         normal_ff[0] <= rdi_pkg::NORMAL_X_RESET;
         normal_ff[1] <= rdi_pkg::NORMAL_Y_RESET;
         normal_ff[2] <= rdi_pkg::NORMAL_Z_RESET;
         radius_ff    <= rdi_pkg::RADIUS_RESET;
         eps_ff       <= rdi_pkg::EPS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rdi_pkg::CSR_CENTRE_X: centre_ff[0] <= csr_wdata[CW-1:0];
            rdi_pkg::CSR_CENTRE_Y: centre_ff[1] <= csr_wdata[CW-1:0];
            rdi_pkg::CSR_CENTRE_Z: centre_ff[2] <= csr_wdata[CW-1:0];
            rdi_pkg::CSR_NORMAL_X: normal_ff[0] <= csr_wdata[NW-1:0];
            rdi_pkg::CSR_NORMAL_Y: normal_ff[1] <= csr_wdata[NW-1:0];
            rdi_pkg::CSR_NORMAL_Z: normal_ff[2] <= csr_wdata[NW-1:0];
            rdi_pkg::CSR_RADIUS:   radius_ff    <= csr_wdata[RW-1:0];
            rdi_pkg::CSR_EPSILON:  eps_ff       <= csr_wdata[rdi_pkg::EPS_WIDTH-1:0];
         endcase
      end
   end

   // R^2 kept registered; the user must change registers only while the pipe is empty (not enforced)
   always_ff @(posedge clock) begin
      radius_sq_ff <= (2*RW)'(radius_ff) * (2*RW)'(radius_ff);
   end

   // ---- item entry ----
   logic                 accept;
   logic signed [CW-1:0] req_org [3];
   logic signed [CW-1:0] req_dir [3];

   assign busy   = reset;
   assign accept = start && !busy;

   assign req_org[0] = req_ray_origin_x;
   assign req_org[1] = req_ray_origin_y;
   assign req_org[2] = req_ray_origin_z;
   assign req_dir[0] = req_ray_dir_x;
   assign req_dir[1] = req_ray_dir_y;
   assign req_dir[2] = req_ray_dir_z;

   // ---- pipeline registers ----
   logic                  s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic signed [CW:0]    s1_co_ff [3], s2_co_ff [3], s3_co_ff [3], s4_co_ff [3];
   logic signed [CW-1:0]  s1_dir_ff [3], s2_dir_ff [3], s3_dir_ff [3], s4_dir_ff [3];
   logic signed [NDW-1:0] s2_nd_ff [3];
   logic signed [NCW-1:0] s2_nc_ff [3];
   logic signed [DEN_W-1:0] s3_den_ff;
   logic signed [NUM_W-1:0] s3_num_ff;
   logic [DEN_W-1:0]      s4_den_mag_ff, s5_den_mag_ff;
   logic [NUM_W-1:0]      s4_num_mag_ff, s5_num_mag_ff;
   logic                  s4_neg_ff;
   rdi_pkg::div_ctrl_type s5_ctrl_ff;
   logic [SIDE_W-1:0]     s5_side_ff;

   // stage 1: c - o
   // stage 2: products with the normal
   // stage 3: dot products
   // stage 4: magnitudes and quotient sign
   // stage 5: parallel test, into the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_ctrl_ff  <= '0;
      end else begin
         s1_valid_ff         <= accept;
         s2_valid_ff         <= s1_valid_ff;
         s3_valid_ff         <= s2_valid_ff;
         s4_valid_ff         <= s3_valid_ff;
         s5_ctrl_ff.valid    <= s4_valid_ff;
         s5_ctrl_ff.neg      <= s4_neg_ff;
         s5_ctrl_ff.parallel <= s4_den_mag_ff <=
            DEN_W'({eps_ff, {rdi_pkg::NORM_FRAC{1'b0}}});
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s1_co_ff[i]  <= (CW+1)'(centre_ff[i]) - (CW+1)'(req_org[i]);
         s1_dir_ff[i] <= req_dir[i];
         s2_nd_ff[i]  <= NDW'(normal_ff[i]) * NDW'(s1_dir_ff[i]);
         s2_nc_ff[i]  <= NCW'(normal_ff[i]) * NCW'(s1_co_ff[i]);
         s2_co_ff[i]  <= s1_co_ff[i];
         s2_dir_ff[i] <= s1_dir_ff[i];
         s3_co_ff[i]  <= s2_co_ff[i];
         s3_dir_ff[i] <= s2_dir_ff[i];
         s4_co_ff[i]  <= s3_co_ff[i];
         s4_dir_ff[i] <= s3_dir_ff[i];
      end
      s3_den_ff <= DEN_W'(s2_nd_ff[0]) + DEN_W'(s2_nd_ff[1]) + DEN_W'(s2_nd_ff[2]);
      s3_num_ff <= NUM_W'(s2_nc_ff[0]) + NUM_W'(s2_nc_ff[1]) + NUM_W'(s2_nc_ff[2]);
      s4_den_mag_ff <= s3_den_ff[DEN_W-1] ? unsigned'(-s3_den_ff) : unsigned'(s3_den_ff);
      s4_num_mag_ff <= s3_num_ff[NUM_W-1] ? unsigned'(-s3_num_ff) : unsigned'(s3_num_ff);
      s4_neg_ff     <= s3_den_ff[DEN_W-1] ^ s3_num_ff[NUM_W-1];
      s5_den_mag_ff <= s4_den_mag_ff;
      s5_num_mag_ff <= s4_num_mag_ff;
      s5_side_ff    <= {s4_co_ff[0], s4_co_ff[1], s4_co_ff[2],
                        s4_dir_ff[0], s4_dir_ff[1], s4_dir_ff[2]};
   end

   // ---- t = n.(c - o) / n.d ----
   rdi_pkg::div_ctrl_type dv_ctrl;
   logic [QUOT_W-1:0]     dv_quot;
   logic                  dv_sat;
   logic [SIDE_W-1:0]     dv_side;
   logic signed [CW:0]    dv_co [3];
   logic signed [CW-1:0]  dv_dir [3];

   rdi_divider #(
      .NUM_W     (NUM_W),
      .DEN_W     (DEN_W),
      .QUOT_W    (QUOT_W),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (SIDE_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .in_ctrl  (s5_ctrl_ff),
      .in_num   (s5_num_mag_ff),
      .in_den   (s5_den_mag_ff),
      .in_side  (s5_side_ff),
      .out_ctrl (dv_ctrl),
      .out_quot (dv_quot),
      .out_sat  (dv_sat),
      .out_side (dv_side)
   );

   for (genvar i = 0; i < 3; i++) begin : g_unpack
      assign dv_co[i]  = dv_side[3*CW + (2-i)*(CW+1) +: CW+1];
      assign dv_dir[i] = dv_side[(2-i)*CW +: CW];
   end

   // ---- hit point and radius test ----
   localparam logic [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

   logic [CW-1:0]         t_mag;
   logic signed [CW-1:0]  t_in;
   logic signed [PW-1:0]  prod_shift [3];

   rdi_pkg::div_ctrl_type s6_ctrl_ff, s7_ctrl_ff, s8_ctrl_ff, s9_ctrl_ff;
   rdi_pkg::div_ctrl_type s10_ctrl_ff, s11_ctrl_ff, s12_ctrl_ff;
   logic signed [CW-1:0]  s6_t_ff, s7_t_ff, s8_t_ff, s9_t_ff, s10_t_ff, s11_t_ff, s12_t_ff;
   logic signed [CW:0]    s6_co_ff [3], s7_co_ff [3];
   logic signed [CW-1:0]  s6_dir_ff [3];
   logic signed [PW-1:0]  s7_prod_ff [3];
   logic signed [EW-1:0]  s8_err_ff [3];
   logic [EW-1:0]         s9_mag_ff [3];
   logic [2:0]            s10_big_ff;
   logic [RW-1:0]         s10_mag_ff [3];
   logic                  s11_big_ff, s12_big_ff;
   logic [2*RW-1:0]       s11_sq_ff [3];
   logic [SW-1:0]         s12_sum_ff;

   logic                  rsp_valid_ff;
   rdi_pkg::status_type   rsp_status_ff;
   logic signed [CW-1:0]  rsp_distance_ff;
   logic                  outside;

   // quotient magnitude to signed t, saturated at either end
   assign t_mag = {1'b0, dv_quot};
   always_comb begin
      if (dv_sat) begin
         t_in = dv_ctrl.neg ? T_MIN : T_MAX;
      end else begin
         t_in = dv_ctrl.neg ? -t_mag : t_mag;
      end
   end

   // floor of t*d in Q.FRAC_BITS
   for (genvar i = 0; i < 3; i++) begin : g_shift
      assign prod_shift[i] = s7_prod_ff[i] >>> FRAC_BITS;
   end

   assign outside = s12_big_ff || (s12_sum_ff > SW'(radius_sq_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_ctrl_ff   <= '0;
         s7_ctrl_ff   <= '0;
         s8_ctrl_ff   <= '0;
         s9_ctrl_ff   <= '0;
         s10_ctrl_ff  <= '0;
         s11_ctrl_ff  <= '0;
         s12_ctrl_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s6_ctrl_ff   <= dv_ctrl;
         s7_ctrl_ff   <= s6_ctrl_ff;
         s8_ctrl_ff   <= s7_ctrl_ff;
         s9_ctrl_ff   <= s8_ctrl_ff;
         s10_ctrl_ff  <= s9_ctrl_ff;
         s11_ctrl_ff  <= s10_ctrl_ff;
         s12_ctrl_ff  <= s11_ctrl_ff;
         rsp_valid_ff <= s12_ctrl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      s6_t_ff  <= t_in;
      s7_t_ff  <= s6_t_ff;
      s8_t_ff  <= s7_t_ff;
      s9_t_ff  <= s8_t_ff;
      s10_t_ff <= s9_t_ff;
      s11_t_ff <= s10_t_ff;
      s12_t_ff <= s11_t_ff;
      for (int i = 0; i < 3; i++) begin
         s6_co_ff[i]   <= dv_co[i];
         s6_dir_ff[i]  <= dv_dir[i];
         s7_co_ff[i]   <= s6_co_ff[i];
         s7_prod_ff[i] <= PW'(s6_t_ff) * PW'(s6_dir_ff[i]);
         s8_err_ff[i]  <= EW'(prod_shift[i]) - EW'(s7_co_ff[i]);
         s9_mag_ff[i]  <= s8_err_ff[i][EW-1] ? unsigned'(-s8_err_ff[i])
                                             : unsigned'(s8_err_ff[i]);
         s10_big_ff[i] <= s9_mag_ff[i] > EW'(radius_ff);
         s10_mag_ff[i] <= s9_mag_ff[i][RW-1:0];
         s11_sq_ff[i]  <= (2*RW)'(s10_mag_ff[i]) * (2*RW)'(s10_mag_ff[i]);
      end
      // a component beyond R is outside before squaring
      s11_big_ff <= |s10_big_ff;
      s12_big_ff <= s11_big_ff;
      s12_sum_ff <= SW'(s11_sq_ff[0]) + SW'(s11_sq_ff[1]) + SW'(s11_sq_ff[2]);

      if (s12_ctrl_ff.parallel) begin
         rsp_status_ff   <= rdi_pkg::STATUS_PARALLEL;
         rsp_distance_ff <= '0;
      end else if (outside) begin
         rsp_status_ff   <= rdi_pkg::STATUS_OUTSIDE;
         rsp_distance_ff <= '0;
      end else begin
         rsp_status_ff   <= rdi_pkg::STATUS_HIT;
         rsp_distance_ff <= s12_t_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit_status   = rsp_status_ff;
   assign rsp_hit_distance = rsp_distance_ff;

endmodule

FILE: rtl/core/rdi_checker.sv
// ----------------------------------------------------------------------------
// rdi_checker
// Port-level checks on the ray/disk intersection core, bound to the top.
// ----------------------------------------------------------------------------
`include "ray_disk_intersection_core_defines.svh"

module rdi_checker #(
   parameter int COORD_WIDTH = rdi_pkg::COORD_WIDTH_DEFAULT,
   parameter int LATENCY     = rdi_pkg::COORD_WIDTH_DEFAULT + 13
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [1:0]                    rsp_hit_status,
   input logic signed [COORD_WIDTH-1:0] rsp_hit_distance
);

   logic item_taken;
   logic miss_rsp;

   assign item_taken = start && !busy;
   assign miss_rsp   = rsp_valid && (rsp_hit_status != rdi_pkg::STATUS_HIT);

   // every result traces back to an item taken earlier
   `RDI_ASSERT(a_rsp_from_item, clock, reset, rsp_valid |-> $past(item_taken, LATENCY), "stray result")

   // parallel and outside results carry no distance
   `RDI_ASSERT(a_miss_no_dist, clock, reset, miss_rsp |-> (rsp_hit_distance == '0), "miss distance")

   // reset empties the pipe
   `RDI_ASSERT_ALWAYS(a_reset_flush, clock, $past(reset) |-> !rsp_valid, "result after reset")

endmodule

bind ray_disk_intersection_core rdi_checker #(
   .COORD_WIDTH (COORD_WIDTH),
   .LATENCY     (LATENCY)
) u_rdi_checker (.*);

FILE: bench/tb_ray_disk_intersection_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ray/disk intersection core testbench
// Streams rays through the core under several disk set-ups, predicts each
// status and distance in fixed point and checks every result in order.
// ----------------------------------------------------------------------------
module tb_ray_disk_intersection_core;

   localparam int CW          = 32;
   localparam int FB          = 16;
   localparam int PIPE_DEPTH  = CW + 13;   // result latency of the core
   localparam int STALL_LIMIT = 4000;      // cycles with no traffic before giving up

   typedef struct {
      logic signed [CW-1:0] org[3];
      logic signed [CW-1:0] dir[3];
   } ray_type;

   typedef struct {
      rdi_pkg::status_type  status;
      logic signed [CW-1:0] distance;
   } hit_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic signed [CW-1:0] req_ray_origin_x = '0, req_ray_origin_y = '0, req_ray_origin_z = '0;
   logic signed [CW-1:0] req_ray_dir_x = '0, req_ray_dir_y = '0, req_ray_dir_z = '0;
   logic                 rsp_valid;
   logic [1:0]           rsp_hit_status;
   logic signed [CW-1:0] rsp_hit_distance;
   logic                 csr_we = 1'b0;
   logic [2:0]           csr_index = '0;
   logic [CW-1:0]        csr_wdata = '0;

   ray_disk_intersection_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // disk set-up as the core should hold it
   longint disk_centre[3] = '{0, 0, 0};
   longint disk_normal[3] = '{0, 16384, 0};
   longint disk_radius    = 65536;
   longint par_eps        = 16;

   ray_type ray_backlog[$];
   hit_type hits_due[$];
   int      errors      = 0;
   int      rays_sent   = 0;
   int      n_hit = 0, n_par = 0, n_out = 0;
   bit      no_gaps     = 1'b0;

   function automatic bit [63:0] magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // plane distance, parallel test, then radius test on squares
   function automatic hit_type trace_disk(input ray_type r);
      longint    o[3], d[3], co[3];
      longint    den, num, t, off;
      bit [63:0] a, b, q, rem, m, sum;
      bit        neg;
      hit_type   h;
      den = 0; num = 0; sum = 0;
      h.distance = '0;
      for (int i = 0; i < 3; i++) begin
         o[i]  = longint'(r.org[i]);
         d[i]  = longint'(r.dir[i]);
         co[i] = disk_centre[i] - o[i];
         den  += disk_normal[i] * d[i];
         num  += disk_normal[i] * co[i];
      end
      if (magnitude(den) <= (par_eps << rdi_pkg::NORM_FRAC)) begin
         h.status = rdi_pkg::STATUS_PARALLEL;
         return h;
      end
      a   = magnitude(num);
      b   = magnitude(den);
      neg = (num < 0) != (den < 0);
      q   = a / b;
      rem = a % b;
      if (q >= (64'd1 << (CW - 1 - FB))) begin
         t = neg ? -(64'sd1 <<< (CW - 1)) : (64'sd1 <<< (CW - 1)) - 1;
      end else begin
         for (int i = 0; i < FB; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= b) begin
               rem = rem - b;
               q[0] = 1'b1;
            end
         end
         t = neg ? -longint'(q) : longint'(q);
      end
      for (int i = 0; i < 3; i++) begin
         off = ((t * d[i]) >>> FB) - co[i];   // floor shift of the exact product
         m   = magnitude(off);
         if (m > disk_radius) begin
            h.status = rdi_pkg::STATUS_OUTSIDE;
            return h;
         end
         sum += m * m;
      end
      if (sum > disk_radius * disk_radius) begin
         h.status = rdi_pkg::STATUS_OUTSIDE;
         return h;
      end
      h.status   = rdi_pkg::STATUS_HIT;
      h.distance = t[CW-1:0];
      return h;
   endfunction

   // ---------------------------------------------------------------- driver
   ray_type in_flight;
   int      gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            hits_due.push_back(trace_disk(in_flight));
            rays_sent++;
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (!no_gaps && ray_backlog.size() > 0 && $urandom_range(0, 11) == 0) begin
               gap_left = $urandom_range(0, 16);   // start a burst of idle cycles
               start    <= 1'b0;
            end else if (ray_backlog.size() > 0) begin
               in_flight = ray_backlog.pop_front();
               req_ray_origin_x <= in_flight.org[0];
               req_ray_origin_y <= in_flight.org[1];
               req_ray_origin_z <= in_flight.org[2];
               req_ray_dir_x    <= in_flight.dir[0];
               req_ray_dir_y    <= in_flight.dir[1];
               req_ray_dir_z    <= in_flight.dir[2];
               start            <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------- monitor
   int quiet_cycles = 0;

   always @(posedge clock) begin
      hit_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (hits_due.size() == 0) begin
               $display("%0t: unexpected result status %0d distance %0d",
                        $time, rsp_hit_status, rsp_hit_distance);
               errors++;
            end else begin
               want = hits_due.pop_front();
               if (rsp_hit_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d got %0d",
                           $time, want.status, rsp_hit_status);
                  errors++;
               end
               if (rsp_hit_distance !== want.distance) begin
                  $display("%0t: distance mismatch, expected %0d got %0d",
                           $time, want.distance, rsp_hit_distance);
                  errors++;
               end
               case (want.status)
                  rdi_pkg::STATUS_HIT:      n_hit++;
                  rdi_pkg::STATUS_PARALLEL: n_par++;
                  default:                  n_out++;
               endcase
            end
         end
         // watchdog: any accepted item or result counts as progress
         if (rsp_valid || (start && !busy)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("ray_disk_intersection_core test failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------- stimulus
   task automatic set_reg(input rdi_pkg::csr_index_type idx, input longint val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CW-1:0];
      case (idx) inside
         rdi_pkg::CSR_CENTRE_X, rdi_pkg::CSR_CENTRE_Y, rdi_pkg::CSR_CENTRE_Z:
            disk_centre[idx] = longint'($signed(val[CW-1:0]));
         rdi_pkg::CSR_NORMAL_X, rdi_pkg::CSR_NORMAL_Y, rdi_pkg::CSR_NORMAL_Z:
            disk_normal[idx - 3] = longint'($signed(val[rdi_pkg::NORM_WIDTH-1:0]));
         rdi_pkg::CSR_RADIUS:
            disk_radius = longint'(val[rdi_pkg::RADIUS_WIDTH-1:0]);
         default:
            par_eps = longint'(val[rdi_pkg::EPS_WIDTH-1:0]);
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_disk(input longint cx, cy, cz, nx, ny, nz, rad, eps);
      set_reg(rdi_pkg::CSR_CENTRE_X, cx);
      set_reg(rdi_pkg::CSR_CENTRE_Y, cy);
      set_reg(rdi_pkg::CSR_CENTRE_Z, cz);
      set_reg(rdi_pkg::CSR_NORMAL_X, nx);
      set_reg(rdi_pkg::CSR_NORMAL_Y, ny);
      set_reg(rdi_pkg::CSR_NORMAL_Z, nz);
      set_reg(rdi_pkg::CSR_RADIUS, rad);
      set_reg(rdi_pkg::CSR_EPSILON, eps);
   endtask

   task automatic add_ray(input longint ox, oy, oz, dx, dy, dz);
      ray_type r;
      r.org = '{ox[CW-1:0], oy[CW-1:0], oz[CW-1:0]};
      r.dir = '{dx[CW-1:0], dy[CW-1:0], dz[CW-1:0]};
      ray_backlog.push_back(r);
   endtask

   function automatic longint spread(input longint span);
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   // mostly rays aimed near the disk centre, with noise and near-parallel rays
   task automatic add_random_rays(input int count);
      ray_type r;
      longint  span, aim;
      int      pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 9);
         span = disk_radius / 2;
         if (span > (1 << 22)) span = 1 << 22;
         for (int i = 0; i < 3; i++) begin
            if (pick < 2) begin
               r.org[i] = $urandom;
               r.dir[i] = $urandom;
            end else if (pick == 2) begin
               r.org[i] = CW'(disk_centre[i] + spread(1 << 20));
               r.dir[i] = CW'(spread(3));
            end else begin
               r.org[i] = CW'(disk_centre[i] + spread(1 << 22));
               aim      = disk_centre[i] + spread(span);
               r.dir[i] = CW'(aim - longint'(r.org[i]));
               if (pick == 3) r.dir[i] = r.dir[i] >>> $urandom_range(0, 12);
            end
         end
         ray_backlog.push_back(r);
      end
   endtask

   task automatic drain();
      while (ray_backlog.size() > 0 || start || hits_due.size() > 0) @(posedge clock);
      repeat (PIPE_DEPTH + 5) @(posedge clock);
   endtask

   localparam longint ONE = 65536;
   localparam longint MAXC = 64'sd2147483647;
   localparam longint MINC = -64'sd2147483648;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed rays against the reset disk (unit radius, y-up, at origin)
      add_ray(0, 0, 0, 0, 0, 0);                    // zero direction: parallel
      add_ray(0, 2 * ONE, 0, 0, -ONE, 0);           // straight down onto centre
      add_ray(ONE / 2, ONE, 0, 0, -ONE, 0);         // inside the rim
      add_ray(ONE, ONE, 0, 0, -ONE, 0);             // exactly on the rim
      add_ray(5 * ONE, 2 * ONE, 0, 0, -ONE, 0);     // outside the radius
      add_ray(0, -3 * ONE, 0, 0, -ONE, 0);          // hit behind origin, t negative
      add_ray(0, ONE, 0, ONE, 0, 0);                // in-plane direction: parallel
      add_ray(0, ONE, 0, 0, 16, 0);                 // |n.d| equal to threshold
      add_ray(0, ONE, 0, 0, 17, 0);                 // just above threshold
      add_ray(0, 1 << 30, 0, 0, -17, 0);            // t saturates positive
      add_ray(0, -(1 << 30), 0, 0, -17, 0);         // t saturates negative
      add_ray(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);
      add_ray(MINC, MINC, MINC, MINC, MINC, MINC);
      add_ray(MAXC, MINC, MAXC, MINC, MAXC, MINC);
      add_random_rays(120);
      drain();

      // flat disk facing z, radius of 4 units
      set_disk(3 * ONE, -2 * ONE, ONE, 0, 0, 16384, 4 * ONE, 16);
      add_ray(3 * ONE, -2 * ONE, 5 * ONE, 0, 0, -ONE);
      add_random_rays(140);
      drain();

      // tilted unit-ish normal, tiny threshold
      set_disk(-7 * ONE, 11 * ONE, 2 * ONE, 9459, -9459, 9459, 3 * ONE, 1);
      add_random_rays(140);
      drain();

      // extremes: corner centre, most negative normal, widest radius and threshold
      set_disk(MAXC, MINC, MAXC, longint'(16'h8000), 16384, -16384, MAXC, 65535);
      add_random_rays(110);
      drain();

      // zero radius, zero threshold, non-unit normal
      set_disk(MINC, 0, MAXC, 32767, 1, -1, 0, 0);
      add_ray(0, 0, 0, 0, 0, 0);
      add_random_rays(110);
      drain();

      // random disk, then the back-to-back run with no idling at all
      set_disk(longint'($signed($urandom) >>> 8), longint'($signed($urandom) >>> 8),
               longint'($signed($urandom) >>> 8),
               spread(16384), spread(16384), spread(16384),
               longint'($urandom_range(0, 1 << 24)), longint'($urandom_range(0, 65535)));
      add_random_rays(110);
      drain();
      no_gaps = 1'b1;
      set_disk(ONE, ONE, -ONE, 16384, 0, 0, 8 * ONE, 4);
      add_random_rays(110);
      drain();

      $display("Checked %0d rays over seven disk set-ups: %0d hits, %0d parallel, %0d outside.",
               rays_sent, n_hit, n_par, n_out);
      if (errors == 0) begin
         $display("ray_disk_intersection_core test passed");
      end else begin
         $display("%0d mismatches seen", errors);
         $display("ray_disk_intersection_core test failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rdi_pkg.sv
rtl/core/rdi_divider.sv
rtl/core/ray_disk_intersection_core.sv
rtl/core/rdi_checker.sv
bench/tb_ray_disk_intersection_core.sv
